FILE: sv/lzssd_pkg.sv
// Shared types and constants for the LZSS window decompressor.
`timescale 1ns / 1ps

package lzssd_pkg;

    // History window addressing: 4-bit high nibble plus 8-bit low byte
    localparam int WIN_AW = 12;

    // Bias applied to a reference position and to a reference length
    localparam logic [WIN_AW-1:0] REF_POS_BIAS = 12'd18;
    localparam logic [4:0]        REF_LEN_BIAS = 5'd3;

    // Parse phases
    localparam logic [1:0] PH_FLAG  = 2'd0;
    localparam logic [1:0] PH_TOKEN = 2'd1;
    localparam logic [1:0] PH_HIGH  = 2'd2;

    // Kind of the byte held in the input register
    localparam logic [1:0] K_FLAG = 2'd0;
    localparam logic [1:0] K_LIT  = 2'd1;
    localparam logic [1:0] K_LOW  = 2'd2;
    localparam logic [1:0] K_HIGH = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;    // capture the input item
        logic decode;   // act on the captured byte
        logic rd;       // issue a history read for the next copy byte
        logic emit;     // load one result into the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] kind;      // what the captured byte is
        logic       last_one;  // the pending result is the last of this item
        logic       out_free;  // output register can take a result now
    } t_sts;

endpackage

FILE: sv/lzssd_ctrl.sv
// Sequencing state machine of the LZSS window decompressor.
`timescale 1ns / 1ps

module lzssd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lzssd_pkg::t_sts i_sts,
    output lzssd_pkg::t_cmd o_cmd
);
    import lzssd_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.latch  = i_in_valid && (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_sts.kind)
                    K_LIT:   n_state = S_EMIT;
                    K_HIGH:  n_state = S_READ;
                    default: n_state = S_IDLE;
                endcase
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.last_one ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result emitted while output register is occupied");

    a_read_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> (r_state == S_EMIT))
        else $error("history read not followed by emit state");

endmodule

FILE: sv/lzssd_dpath.sv
// Datapath of the LZSS window decompressor: parse state, history ring, output register.
`timescale 1ns / 1ps

module lzssd_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lzssd_pkg::t_cmd i_cmd,
    output lzssd_pkg::t_sts o_sts,
    input  logic [7:0]      i_comp_byte,
    input  logic            i_end_of_input,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_wdata,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_overflow,
    output logic            o_file_done
);
    import lzssd_pkg::*;

    localparam int WIN_DEPTH = 1 << WIN_AW;

    // History ring; contents undefined until written
    logic [7:0] mem [WIN_DEPTH];

    // Captured input item
    logic [7:0]        r_in_byte;
    logic              r_in_last;

    // Parse state
    logic [1:0]        r_phase,    n_phase;
    logic [7:0]        r_flags,    n_flags;
    logic [2:0]        r_bit_idx,  n_bit_idx;
    logic [7:0]        r_pend_low, n_pend_low;
    logic [31:0]       r_count,    n_count;
    logic [31:0]       r_limit;

    // Copy state
    logic [4:0]        r_remain,   n_remain;
    logic              r_lit,      n_lit;
    logic [WIN_AW-1:0] r_dist,     n_dist;
    logic              r_zero;
    logic [7:0]        r_rd_data;

    // Output register
    logic              r_o_valid;
    logic [7:0]        r_o_byte;
    logic              r_o_last;
    logic              r_o_ovf;
    logic              r_o_done;

    logic [1:0]        kind;
    logic              ovf;
    logic [7:0]        emit_byte;
    logic [2:0]        bit_inc;
    logic              item_end;

    always_comb begin
        case (r_phase)
            PH_TOKEN: kind = r_flags[r_bit_idx] ? K_LIT : K_LOW;
            PH_HIGH:  kind = K_HIGH;
            default:  kind = K_FLAG;
        endcase
    end

    assign ovf       = !(r_count < r_limit);
    assign emit_byte = r_lit ? r_in_byte : (r_zero ? 8'd0 : r_rd_data);
    assign bit_inc   = r_bit_idx + 3'd1;

    assign o_sts.kind     = kind;
    assign o_sts.last_one = (r_remain == 5'd1);
    assign o_sts.out_free = !r_o_valid || i_out_ready;

    always_comb begin
        n_phase    = r_phase;
        n_flags    = r_flags;
        n_bit_idx  = r_bit_idx;
        n_pend_low = r_pend_low;
        n_count    = r_count;
        n_remain   = r_remain;
        n_lit      = r_lit;
        n_dist     = r_dist;
        item_end   = 1'b0;
        if (i_cmd.decode) begin
            case (kind)
                K_FLAG: begin
                    n_flags   = r_in_byte;
                    n_bit_idx = 3'd0;
                    n_phase   = PH_TOKEN;
                    item_end  = 1'b1;
                end
                K_LOW: begin
                    n_pend_low = r_in_byte;
                    n_phase    = PH_HIGH;
                    item_end   = 1'b1;
                end
                K_LIT: begin
                    n_remain = 5'd1;
                    n_lit    = 1'b1;
                end
                K_HIGH: begin
                    n_remain = {1'b0, r_in_byte[3:0]} + REF_LEN_BIAS;
                    n_lit    = 1'b0;
                    n_dist   = r_count[WIN_AW-1:0]
                             - ({r_in_byte[7:4], r_pend_low} + REF_POS_BIAS);
                end
                default: n_remain = r_remain;
            endcase
        end
        if (i_cmd.emit) begin
            n_remain = r_remain - 5'd1;
            if (!ovf) begin
                n_count = r_count + 32'd1;
            end
            if (r_remain == 5'd1) begin
                n_bit_idx = bit_inc;
                n_phase   = (bit_inc == 3'd0) ? PH_FLAG : PH_TOKEN;
                item_end  = 1'b1;
            end
        end
        // Final byte of the file: restart the parse, keep history and limit
        if (item_end && r_in_last) begin
            n_phase    = PH_FLAG;
            n_flags    = 8'd0;
            n_bit_idx  = 3'd0;
            n_pend_low = 8'd0;
            n_count    = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FLAG;
            r_flags    <= 8'd0;
            r_bit_idx  <= 3'd0;
            r_pend_low <= 8'd0;
            r_count    <= 32'd0;
            r_limit    <= 32'hFFFF_FFFF;
            r_remain   <= 5'd0;
            r_lit      <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_flags    <= n_flags;
            r_bit_idx  <= n_bit_idx;
            r_pend_low <= n_pend_low;
            r_count    <= n_count;
            r_remain   <= n_remain;
            r_lit      <= n_lit;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers and history memory
    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
        if (i_cmd.latch) begin
            r_in_byte <= i_comp_byte;
            r_in_last <= i_end_of_input;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_count[WIN_AW-1:0] - r_dist];
            r_zero    <= (r_dist == '0) || (r_count < {{(32-WIN_AW){1'b0}}, r_dist});
        end
        if (i_cmd.emit) begin
            r_o_byte <= emit_byte;
            r_o_last <= (r_remain == 5'd1);
            r_o_ovf  <= ovf;
            r_o_done <= r_in_last;
            if (!ovf) begin
                mem[r_count[WIN_AW-1:0]] <= emit_byte;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_byte  = r_o_byte;
    assign o_run_last  = r_o_last;
    assign o_overflow  = r_o_ovf;
    assign o_file_done = r_o_done;

    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_remain != 5'd0))
        else $error("emit with no bytes left in the token");

    a_emit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_o_valid)
        else $error("emitted result not presented");

    a_count_frozen_on_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && ovf && !(r_remain == 5'd1 && r_in_last)) |=> $stable(r_count))
        else $error("position advanced past the output limit");

endmodule

FILE: sv/lzss_window_decompressor.sv
// Top level of the LZSS decompressor with a 4096-byte history window.
//
// Usage: compressed bytes enter one item at a time on the input channel
// (i_in_valid / o_in_ready, payload i_comp_byte and i_end_of_input). Decoded
// bytes leave one item at a time on the output channel (o_out_valid /
// i_out_ready) with o_run_last on the final byte caused by an input item,
// o_overflow on bytes past the output limit, and o_file_done on every byte
// caused by the final input item of a file.
// Throughput: one input item at a time. A flag byte or the low byte of a
// reference is captured and decoded; a literal is captured, decoded and
// emitted; a reference high byte is captured and decoded, then each copied
// byte needs a history read and then an emit that writes the ring below the
// output limit, so an overlapping copy always sees the byte just written.
// Reset: parse returns to the flag phase, position and flags clear, the
// output limit returns to all ones. The history ring is not cleared.
// Receiver stall: the output register holds its item; the sequencer waits in
// the emit step, and a new input item is still taken once the previous one
// has finished its last emit.
// Configuration: i_cfg_we / i_cfg_wdata write the output limit; write it only
// while the block is idle.
`timescale 1ns / 1ps

module lzss_window_decompressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Compressed input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_comp_byte,
    input  logic        i_end_of_input,
    // Output limit register
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // Decompressed output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_overflow,
    output logic        o_file_done
);
    import lzssd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer: capture, decode, then read/emit per copied byte or emit for a literal
    lzssd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Parse state, history ring and output register
    lzssd_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_comp_byte    (i_comp_byte),
        .i_end_of_input (i_end_of_input),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_overflow     (o_overflow),
        .o_file_done    (o_file_done)
    );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the LZSS 4 KB window decompressor.
`timescale 1ns / 1ps

module tb_top;
    import lzssd_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 64;    // covers the longest item, plus margin
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    // One compressed item as offered on the input channel
    typedef struct packed {
        logic [7:0] val;
        logic       eoi;
    } t_comp_item;

    // One decoded item as seen on the output channel
    typedef struct packed {
        logic [7:0] val;
        logic       run_last;
        logic       overflow;
        logic       file_done;
    } t_dec_byte;

    // Ways a generated file may close
    typedef enum int {
        END_ON_FLAG,
        END_ON_LIT,
        END_ON_LOW,
        END_ON_HIGH
    } t_file_end;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  comp_byte = '0;
    logic        end_of_input = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        overflow;
    logic        file_done;

    // Stimulus and expectations
    t_comp_item  comp_feed_q[$];
    t_dec_byte   decoded_due_q[$];
    t_comp_item  feed_item;
    int          queued_items = 0;
    int          gen_pos = 0;       // output position the generator believes in

    // Handshake bookkeeping
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    logic        in_burst = 1'b0;
    logic        out_burst = 1'b0;
    logic        hold_req = 1'b0;
    int          in_gap = 0;
    int          out_stall = 0;
    int          hold_left = 0;

    // Decoder state mirrored by the predictor
    logic [7:0]  pr_ring [0:4095];
    logic [1:0]  pr_phase;
    logic [7:0]  pr_flags;
    logic [2:0]  pr_bit;
    logic [7:0]  pr_low;
    logic [31:0] pr_pos;
    logic [31:0] pr_limit;

    // Run statistics
    int          cycle_count = 0;
    int          mismatches = 0;
    int          accepted_items = 0;
    int          decoded_bytes = 0;
    int          flagged_bytes = 0;
    int          files_closed = 0;
    int          limit_settings = 0;
    int          fails = 0;

    lzss_window_decompressor u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_comp_byte    (comp_byte),
        .i_end_of_input (end_of_input),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_out_byte     (out_byte),
        .o_run_last     (run_last),
        .o_overflow     (overflow),
        .o_file_done    (file_done)
    );

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic int draw_gap(input logic burst);
        return burst ? 0 : int'($urandom_range(0, 7));
    endfunction

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Store and count one produced byte, or flag it once the limit is reached.
    function automatic t_dec_byte produce_byte(input logic [7:0] b);
        t_dec_byte r;
        r = '0;
        r.val = b;
        if (pr_pos < pr_limit) begin
            pr_ring[pr_pos[11:0]] = b;
            pr_pos++;
        end else begin
            r.overflow = 1'b1;
        end
        return r;
    endfunction

    task automatic advance_token();
        pr_bit   = pr_bit + 3'd1;
        pr_phase = (pr_bit == 3'd0) ? PH_FLAG : PH_TOKEN;
    endtask

    // Work out the decoded items caused by one accepted compressed item.
    task automatic decode_comp_byte(input logic [7:0] b, input logic eoi);
        t_dec_byte   step_q[$];
        t_dec_byte   r;
        logic [11:0] src;
        logic [11:0] back_dist;
        logic [11:0] rd_addr;
        logic [31:0] pos;
        logic [7:0]  cb;
        int          len;
        int          i;
        accepted_items++;
        case (pr_phase)
            PH_TOKEN: begin
                if (pr_flags[pr_bit]) begin
                    step_q.push_back(produce_byte(b));
                    advance_token();
                end else begin
                    pr_low   = b;
                    pr_phase = PH_HIGH;
                end
            end
            PH_HIGH: begin
                // 12-bit arithmetic does the modulo on the window size
                src       = {b[7:4], pr_low} + REF_POS_BIAS;
                len       = int'(b[3:0]) + int'(REF_LEN_BIAS);
                back_dist = pr_pos[11:0] - src;
                for (i = 0; i < len; i++) begin
                    pos     = pr_pos;
                    rd_addr = pos[11:0] - back_dist;
                    // zero distance, or a source before the start of output, reads zero
                    cb = (back_dist != 12'd0 && pos >= {20'd0, back_dist}) ?
                         pr_ring[rd_addr] : 8'h00;
                    step_q.push_back(produce_byte(cb));
                end
                advance_token();
            end
            default: begin
                // flag phase, and the unused phase code acts the same
                pr_flags = b;
                pr_bit   = 3'd0;
                pr_phase = PH_TOKEN;
            end
        endcase
        if (eoi) begin
            pr_phase = PH_FLAG;
            pr_flags = 8'h00;
            pr_bit   = 3'd0;
            pr_low   = 8'h00;
            pr_pos   = 32'd0;
            files_closed++;
        end
        for (i = 0; i < step_q.size(); i++) begin
            r = step_q[i];
            r.run_last  = (i == step_q.size() - 1);
            r.file_done = eoi;
            decoded_due_q.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------------
    // Checker
    // ---------------------------------------------------------------------

    task automatic check_decoded_byte(input t_dec_byte got);
        t_dec_byte want;
        decoded_bytes++;
        if (got.overflow === 1'b1)
            flagged_bytes++;
        if (decoded_due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] unexpected decoded item: val=%02h last=%b ovf=%b done=%b",
                         $realtime, got.val, got.run_last, got.overflow, got.file_done);
        end else begin
            want = decoded_due_q.pop_front();
            if (got.val !== want.val || got.run_last !== want.run_last ||
                got.overflow !== want.overflow || got.file_done !== want.file_done) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] decoded item %0d: want %02h/%b/%b/%b got %02h/%b/%b/%b",
                             $realtime, decoded_bytes,
                             want.val, want.run_last, want.overflow, want.file_done,
                             got.val, got.run_last, got.overflow, got.file_done);
            end
        end
    endtask

    // Sample both channels at the rising edge; predict on input, check on output.
    always @(posedge clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d decoded items still due",
                     cycle_count, decoded_due_q.size());
            $display("FAILURE");
            $finish;
        end else begin
            cycle_count++;
            in_taken  <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            if (rst_n && in_valid && in_ready)
                decode_comp_byte(comp_byte, end_of_input);
            if (rst_n && out_valid && out_ready)
                check_decoded_byte({out_byte, run_last, overflow, file_done});
        end
    end

    // ---------------------------------------------------------------------
    // Driver: present queued items at the falling edge, with random gaps
    // ---------------------------------------------------------------------

    always @(negedge clk) begin
        if (rst_n && (in_taken || !in_valid)) begin
            if (in_taken)
                in_gap = draw_gap(in_burst);
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (comp_feed_q.size() != 0) begin
                feed_item = comp_feed_q.pop_front();
                comp_byte    <= feed_item.val;
                end_of_input <= feed_item.eoi;
                in_valid     <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall after each item, and a long hold-off on request
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (out_taken)
            out_stall = draw_gap(out_burst);
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------------

    task automatic queue_comp_byte(input logic [7:0] b, input logic eoi);
        t_comp_item it;
        it.val = b;
        it.eoi = eoi;
        comp_feed_q.push_back(it);
        queued_items++;
        if (eoi)
            gen_pos = 0;
    endtask

    task automatic queue_literal(input logic [7:0] b, input logic eoi);
        gen_pos++;
        queue_comp_byte(b, eoi);
    endtask

    // Encode a copy from back_dist bytes back; close the file on either byte.
    task automatic queue_reference(input int back_dist, input int len,
                                   input logic end_low, input logic end_high);
        logic [11:0] code;
        code = 12'(gen_pos - back_dist) - REF_POS_BIAS;
        queue_comp_byte(code[7:0], end_low);
        if (!end_low) begin
            gen_pos += len;
            queue_comp_byte({code[11:8], 4'(len - int'(REF_LEN_BIAS))}, end_high);
        end
    endtask

    // Mostly short distances into real data, some degenerate sources.
    function automatic int pick_copy_distance();
        int span;
        int d;
        span = (gen_pos < 1) ? 1 : ((gen_pos > 64) ? 64 : gen_pos);
        case ($urandom_range(0, 9))
            0:       d = 0;
            1:       d = gen_pos + int'($urandom_range(1, 300));
            2:       d = int'($urandom_range(0, 4095));
            default: d = int'($urandom_range(1, span));
        endcase
        return d;
    endfunction

    task automatic queue_file_end(input t_file_end how);
        case (how)
            END_ON_FLAG: queue_comp_byte(8'($urandom), 1'b1);
            END_ON_LIT: begin
                queue_comp_byte(8'($urandom) | 8'h01, 1'b0);
                queue_literal(8'($urandom), 1'b1);
            end
            END_ON_LOW: begin
                queue_comp_byte(8'($urandom) & 8'hFE, 1'b0);
                queue_reference(pick_copy_distance(), 3, 1'b1, 1'b0);
            end
            default: begin
                queue_comp_byte(8'($urandom) & 8'hFE, 1'b0);
                queue_reference(pick_copy_distance(), int'($urandom_range(3, 18)),
                                1'b0, 1'b1);
            end
        endcase
    endtask

    // Well-formed flag groups with random content, some noise and broken files.
    task automatic queue_random_stream(input int n_items);
        int         stop_at;
        int         k;
        logic [7:0] flags;
        stop_at = queued_items + n_items;
        while (queued_items < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise lands in any parse phase; close the file to resync
                repeat ($urandom_range(1, 6))
                    queue_comp_byte(8'($urandom), 1'b0);
                queue_comp_byte(8'($urandom), 1'b1);
            end else begin
                flags = 8'($urandom);
                queue_comp_byte(flags, 1'b0);
                for (k = 0; k < 8; k++) begin
                    if (flags[k])
                        queue_literal(8'($urandom), 1'b0);
                    else
                        queue_reference(pick_copy_distance(), int'($urandom_range(3, 18)),
                                        1'b0, 1'b0);
                end
                if ($urandom_range(0, 3) == 0)
                    queue_file_end(t_file_end'($urandom_range(0, 3)));
            end
        end
    endtask

    // Wait until every item is in, every result is out, and the block is quiet.
    task automatic settle_idle();
        while (comp_feed_q.size() != 0 || in_valid || decoded_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        pr_limit = v;
        limit_settings++;
    endtask

    task automatic run_phase(input logic [31:0] limit, input int n_items,
                             input logic burst_in, input logic burst_out,
                             input logic long_hold);
        settle_idle();
        write_limit(limit);
        in_burst  = burst_in;
        out_burst = burst_out;
        if (long_hold)
            hold_req = 1'b1;
        queue_random_stream(n_items);
    endtask

    initial begin
        for (int a = 0; a < 4096; a++)
            pr_ring[a] = 8'h00;
        pr_phase = PH_FLAG;
        pr_flags = 8'h00;
        pr_bit   = 3'd0;
        pr_low   = 8'h00;
        pr_pos   = 32'd0;
        pr_limit = 32'hFFFF_FFFF;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_limit(32'hFFFF_FFFF);

        // Literals at both byte extremes, then each kind of copy source
        queue_comp_byte(8'h0F, 1'b0);
        queue_literal(8'h00, 1'b0);
        queue_literal(8'hFF, 1'b0);
        queue_literal(8'hA5, 1'b0);
        queue_literal(8'h5A, 1'b0);
        queue_reference(0, 18, 1'b0, 1'b0);     // source at current position, longest copy
        queue_reference(100, 3, 1'b0, 1'b0);    // source before start of output
        queue_reference(23, 5, 1'b0, 1'b0);     // plain back-reference
        queue_reference(5, 12, 1'b0, 1'b1);     // overlapping copy, file closes on high byte
        queue_comp_byte(8'hAA, 1'b1);           // file closes on a flag byte: nothing out
        queue_comp_byte(8'h01, 1'b0);
        queue_literal(8'h3C, 1'b1);             // file closes on a literal
        queue_comp_byte(8'h00, 1'b0);
        queue_reference(7, 9, 1'b1, 1'b0);      // file closes on a low byte: dropped

        // Small limit: the fourth literal and the whole copy run past it
        settle_idle();
        write_limit(32'd3);
        queue_comp_byte(8'hEF, 1'b0);
        queue_literal(8'h11, 1'b0);
        queue_literal(8'h22, 1'b0);
        queue_literal(8'h33, 1'b0);
        queue_literal(8'h44, 1'b0);
        queue_reference(2, 4, 1'b0, 1'b1);

        // Random streams under several limits and handshake mixes
        run_phase(32'd0, 50, 1'b0, 1'b0, 1'b0);
        run_phase(32'($urandom_range(10, 120)), 60, 1'b1, 1'b1, 1'b0);
        run_phase(32'hFFFF_FFFF, 80, 1'b0, 1'b0, 1'b1);
        run_phase(32'($urandom_range(200, 2000)), 60, 1'b1, 1'b0, 1'b0);
        run_phase(32'h8000_0000, 50, 1'b0, 1'b1, 1'b0);
        settle_idle();

        fails = mismatches + decoded_due_q.size();
        if (decoded_due_q.size() != 0)
            $display("%0d decoded items never arrived", decoded_due_q.size());
        $display("Covered %0d compressed items, %0d decoded items (%0d past the limit),",
                 accepted_items, decoded_bytes, flagged_bytes);
        $display("%0d file ends and %0d output-limit settings; %0d mismatches.",
                 files_closed, limit_settings, mismatches);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
